### design/ttlkc_pkg.sv
package ttlkc_pkg;

  // fixed field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned TTL_W    = 16;

  // largest removed count the result can carry
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_GET    = 3'd1,
    OP_DELETE = 3'd2,
    OP_FIND   = 3'd3,
    OP_TICK   = 3'd4,
    OP_SWEEP  = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_MISS     = 3'd1,
    ST_EXPIRED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_DISABLED = 3'd4
  } status_e;

  // operation broadcast to the cell row
  typedef enum logic [2:0] {
    COP_IDLE   = 3'd0,
    COP_INSERT = 3'd1,
    COP_GET    = 3'd2,
    COP_DELETE = 3'd3,
    COP_FIND   = 3'd4,
    COP_SWEEP  = 3'd5
  } cell_op_e;

  // command seen by every cell
  typedef struct packed {
    logic     en;
    cell_op_e op;
    logic     perm;
    logic     refresh;
    logic     any_match;
  } cmd_t;

  // priority flags passed from the oldest cell toward the newest
  typedef struct packed {
    logic sel_seen;
    logic rem_seen;
    logic hit_expired;
  } chain_t;

endpackage

### design/ttl_keyed_cache_table_unit.sv
// Keyed table of up to TABLE_DEPTH entries with time-to-live expiry, kept
// packed in insertion order in a row of cells (cell 0 holds the oldest entry).
// One request is handled at a time: it is taken in one cycle and executed in
// the next, where every cell compares its key or value in parallel and one
// removal compacts the row by moving each later entry down one cell. A sweep
// removes one expired entry per execute cycle until none is left; every other
// request executes once. The result sits in an output register, and the next
// request is taken in the same cycle that the result is taken. The cycle
// time is set by the priority chain that runs through all cells. The user
// must write the time-to-live register only while the table is idle; the
// block does not enforce it. A zero value makes get and sweep report disabled.
module ttl_keyed_cache_table_unit #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned VALUE_BITS  = 32,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [ttlkc_pkg::TTL_W-1:0]     cfg_wdata_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ttlkc_pkg::OP_W-1:0]      opcode_i,
  input  logic [KEY_BITS-1:0]             lookup_key_i,
  input  logic [VALUE_BITS-1:0]           entry_value_i,
  input  logic                            is_permanent_i,
  input  logic                            refresh_stamp_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ttlkc_pkg::STATUS_W-1:0]  status_o,
  output logic [VALUE_BITS-1:0]           value_out_o,
  output logic [KEY_BITS-1:0]             key_out_o,
  output logic [ttlkc_pkg::COUNT_W-1:0]   removed_count_o
);
  import ttlkc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [TTL_W-1:0]   ttl_q;
  logic [STAMP_W-1:0] time_q, time_d;
  logic [COUNT_W-1:0] count_q, count_d;

  // registered request
  op_e                   op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  perm_q;
  logic                  refresh_q;

  // result registers
  status_e               status_q, status_d;
  logic [VALUE_BITS-1:0] vout_q, vout_d;
  logic [KEY_BITS-1:0]   kout_q, kout_d;
  logic [COUNT_W-1:0]    removed_q, removed_d;

  logic accept;
  logic finish;
  logic ttl_zero;
  cmd_t cmd;

  // cell row wiring
  chain_t                chain      [TABLE_DEPTH+1];
  logic [KEY_BITS-1:0]   found_key  [TABLE_DEPTH+1];
  logic [VALUE_BITS-1:0] found_data [TABLE_DEPTH+1];
  logic                  ent_valid  [TABLE_DEPTH+1];
  logic [KEY_BITS-1:0]   ent_key    [TABLE_DEPTH+1];
  logic [VALUE_BITS-1:0] ent_data   [TABLE_DEPTH+1];
  logic [STAMP_W-1:0]    ent_stamp  [TABLE_DEPTH+1];
  logic                  ent_forever[TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] key_match;

  // handshake
  assign in_ready_o  = (state_q == S_IDLE) || (state_q == S_DONE && out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_DONE);
  assign ttl_zero    = (ttl_q == '0);

  // command to the cells
  always_comb begin
    cmd.en        = (state_q == S_EXEC);
    cmd.perm      = perm_q;
    cmd.refresh   = refresh_q;
    cmd.any_match = |key_match;
    unique case (op_q)
      OP_INSERT: cmd.op = COP_INSERT;
      OP_GET:    cmd.op = ttl_zero ? COP_IDLE : COP_GET;
      OP_DELETE: cmd.op = COP_DELETE;
      OP_FIND:   cmd.op = COP_FIND;
      OP_SWEEP:  cmd.op = ttl_zero ? COP_IDLE : COP_SWEEP;
      default:   cmd.op = COP_IDLE;
    endcase
  end

  // chain ends: nothing older than cell 0, an empty slot past the last cell
  assign chain[0]                 = '0;
  assign found_key[0]             = '0;
  assign found_data[0]            = '0;
  assign ent_valid[TABLE_DEPTH]   = 1'b0;
  assign ent_key[TABLE_DEPTH]     = '0;
  assign ent_data[TABLE_DEPTH]    = '0;
  assign ent_stamp[TABLE_DEPTH]   = '0;
  assign ent_forever[TABLE_DEPTH] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ttlkc_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .key_i       (key_q),
      .value_i     (value_q),
      .now_i       (time_q),
      .ttl_i       (ttl_q),
      .chain_i     (chain[i]),
      .found_key_i (found_key[i]),
      .found_data_i(found_data[i]),
      .chain_o     (chain[i+1]),
      .found_key_o (found_key[i+1]),
      .found_data_o(found_data[i+1]),
      .key_match_o (key_match[i]),
      .nb_valid_i  (ent_valid[i+1]),
      .nb_key_i    (ent_key[i+1]),
      .nb_data_i   (ent_data[i+1]),
      .nb_stamp_i  (ent_stamp[i+1]),
      .nb_forever_i(ent_forever[i+1]),
      .valid_o     (ent_valid[i]),
      .key_o       (ent_key[i]),
      .data_o      (ent_data[i]),
      .stamp_o     (ent_stamp[i]),
      .forever_o   (ent_forever[i])
    );
  end

  // result of the execute cycle
  always_comb begin
    status_d  = ST_OK;
    vout_d    = '0;
    kout_d    = '0;
    removed_d = '0;
    time_d    = time_q;
    count_d   = count_q;
    finish    = 1'b1;
    unique case (op_q)
      OP_INSERT: begin
        status_d = chain[TABLE_DEPTH].sel_seen ? ST_OK : ST_FULL;
      end
      OP_GET: begin
        if (ttl_zero) begin
          status_d = ST_DISABLED;
        end else if (!chain[TABLE_DEPTH].sel_seen) begin
          status_d = ST_MISS;
        end else if (chain[TABLE_DEPTH].hit_expired) begin
          status_d  = ST_EXPIRED;
          removed_d = COUNT_W'(1);
        end else begin
          vout_d = found_data[TABLE_DEPTH];
        end
      end
      OP_DELETE: begin
        if (chain[TABLE_DEPTH].sel_seen) begin
          removed_d = COUNT_W'(1);
        end else begin
          status_d = ST_MISS;
        end
      end
      OP_FIND: begin
        if (chain[TABLE_DEPTH].sel_seen) begin
          kout_d = found_key[TABLE_DEPTH];
        end else begin
          status_d = ST_MISS;
        end
      end
      OP_TICK: begin
        time_d = time_q + STAMP_W'(1);
      end
      OP_SWEEP: begin
        if (ttl_zero) begin
          status_d = ST_DISABLED;
        end else if (chain[TABLE_DEPTH].rem_seen) begin
          // one expired entry leaves per cycle
          finish  = 1'b0;
          count_d = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + COUNT_W'(1);
        end else begin
          removed_d = count_q;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (finish) state_d = S_DONE;
      S_DONE: begin
        if (out_ready_i) state_d = accept ? S_EXEC : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ttl_q   <= '0;
      time_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) ttl_q <= cfg_wdata_i;
      if (accept) begin
        count_q <= '0;
      end else if (state_q == S_EXEC) begin
        count_q <= count_d;
      end
      if (state_q == S_EXEC) time_q <= time_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_e'(opcode_i);
      key_q     <= lookup_key_i;
      value_q   <= entry_value_i;
      perm_q    <= is_permanent_i;
      refresh_q <= refresh_stamp_i;
    end
    if (state_q == S_EXEC && finish) begin
      status_q  <= status_d;
      vout_q    <= vout_d;
      kout_q    <= kout_d;
      removed_q <= removed_d;
    end
  end

  assign status_o        = status_q;
  assign value_out_o     = vout_q;
  assign key_out_o       = kout_q;
  assign removed_count_o = removed_q;

endmodule

### design/ttlkc_cell.sv
module ttlkc_cell #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ttlkc_pkg::cmd_t          cmd_i,
  input  logic [KEY_BITS-1:0]      key_i,
  input  logic [VALUE_BITS-1:0]    value_i,
  input  logic [ttlkc_pkg::STAMP_W-1:0] now_i,
  input  logic [ttlkc_pkg::TTL_W-1:0]   ttl_i,
  // priority chain from the older neighbor
  input  ttlkc_pkg::chain_t        chain_i,
  input  logic [KEY_BITS-1:0]      found_key_i,
  input  logic [VALUE_BITS-1:0]    found_data_i,
  output ttlkc_pkg::chain_t        chain_o,
  output logic [KEY_BITS-1:0]      found_key_o,
  output logic [VALUE_BITS-1:0]    found_data_o,
  output logic                     key_match_o,
  // entry of the newer neighbor, taken on compaction
  input  logic                     nb_valid_i,
  input  logic [KEY_BITS-1:0]      nb_key_i,
  input  logic [VALUE_BITS-1:0]    nb_data_i,
  input  logic [ttlkc_pkg::STAMP_W-1:0] nb_stamp_i,
  input  logic                     nb_forever_i,
  // own entry, handed to the older neighbor
  output logic                     valid_o,
  output logic [KEY_BITS-1:0]      key_o,
  output logic [VALUE_BITS-1:0]    data_o,
  output logic [ttlkc_pkg::STAMP_W-1:0] stamp_o,
  output logic                     forever_o
);
  import ttlkc_pkg::*;

  logic                  valid_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] data_q;
  logic [STAMP_W-1:0]    stamp_q;
  logic                  forever_q;

  logic [STAMP_W-1:0] age;
  logic               expired;
  logic               kmatch;
  logic               dmatch;
  logic               sel;
  logic               rem;
  logic               sel_first;
  logic               shift;

  // age wraps modulo the stamp width
  assign age     = now_i - stamp_q;
  assign expired = !forever_q && (age >= {{(STAMP_W-TTL_W){1'b0}}, ttl_i});
  assign kmatch  = valid_q && (key_q == key_i);
  assign dmatch  = valid_q && (data_q == value_i);

  // select and removal flags per operation
  always_comb begin
    sel = 1'b0;
    rem = 1'b0;
    unique case (cmd_i.op)
      COP_INSERT: sel = kmatch || (!cmd_i.any_match && !valid_q);
      COP_GET: begin
        sel = kmatch;
        rem = kmatch && expired;
      end
      COP_DELETE: begin
        sel = kmatch;
        rem = kmatch;
      end
      COP_FIND:  sel = dmatch;
      COP_SWEEP: rem = valid_q && expired;
      default: begin
        sel = 1'b0;
        rem = 1'b0;
      end
    endcase
  end

  // only the oldest flagged cell counts; all cells above a removal move down
  assign sel_first = sel && !chain_i.sel_seen;
  assign shift     = rem || chain_i.rem_seen;

  assign chain_o.sel_seen    = chain_i.sel_seen || sel;
  assign chain_o.rem_seen    = chain_i.rem_seen || rem;
  assign chain_o.hit_expired = sel_first ? expired : chain_i.hit_expired;
  assign found_key_o         = sel_first ? key_q : found_key_i;
  assign found_data_o        = sel_first ? data_q : found_data_i;
  assign key_match_o         = kmatch;

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.en) begin
      if (shift) begin
        valid_q <= nb_valid_i;
      end else if (cmd_i.op == COP_INSERT && sel_first) begin
        valid_q <= 1'b1;
      end
    end
  end

  // entry contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      if (shift) begin
        key_q     <= nb_key_i;
        data_q    <= nb_data_i;
        stamp_q   <= nb_stamp_i;
        forever_q <= nb_forever_i;
      end else if (cmd_i.op == COP_INSERT && sel_first) begin
        key_q     <= key_i;
        data_q    <= value_i;
        stamp_q   <= now_i;
        forever_q <= cmd_i.perm;
      end else if (cmd_i.op == COP_GET && sel_first && cmd_i.refresh && !forever_q) begin
        stamp_q   <= now_i;
      end
    end
  end

  assign valid_o   = valid_q;
  assign key_o     = key_q;
  assign data_o    = data_q;
  assign stamp_o   = stamp_q;
  assign forever_o = forever_q;

endmodule
